@@ hw/rtl/chull_pkg.sv @@
// ----------------------------------------------------------------------------
// chull_pkg: shared types and codes for the monotone convex hull trick block
// Request kinds, result status codes and the stored line format.
// ----------------------------------------------------------------------------
`default_nettype none

package chull_pkg;

	localparam int SlopeW = 32;
	localparam int IcptW  = 48;
	localparam int XW     = 32;
	localparam int ValW   = 64;
	localparam int CountW = 13;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_SLOPE = 2'd3
	} status_t;

	// One line of the hull as it is held in memory.
	typedef struct packed {
		logic signed [IcptW-1:0]  icpt;
		logic signed [SlopeW-1:0] slope;
	} line_t;

endpackage

`default_nettype wire

@@ hw/rtl/monotone_convex_hull_trick.sv @@
// ----------------------------------------------------------------------------
// monotone_convex_hull_trick: upper envelope of lines for maximum queries
// Stack of lines with increasing slopes held in one synchronous memory.
// ----------------------------------------------------------------------------
// A transaction runs from acceptance to the next possible acceptance, and its
// result is valid from the return to IDLE. An insert that is neither dropped
// nor into an empty hull runs pop tests until the top line stays; a query runs
// a binary search of ceil(log2 n) steps. A stalled result holds the block in
// DONE. The pop loop and the search loop over the single read port of the line
// memory set the rate; one transaction is worked on at a time.
// Reset clears the line count and the handshake state; the line memory is
// not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module monotone_convex_hull_trick #(
	parameter int HULL_DEPTH = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// s_tdata, low bit up: line_slope[31:0], line_intercept[79:32], query_x[111:80]
	input  wire logic [111:0] s_tdata,
	// s_tuser: req_type[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// m_tdata, low bit up: best_value[63:0], line_count[76:64], zero pad[79:77]
	output logic [79:0]       m_tdata,
	// m_tuser: status[1:0]
	output logic [1:0]        m_tuser
);

	localparam int AW = $clog2(HULL_DEPTH);
	localparam int CW = $clog2(HULL_DEPTH + 1);

	typedef enum logic [3:0] {
		IDLE, INS_TOP, POP_CHK, POP_R1, POP_R2, POP_M1, POP_M2, POP_M3, PUSH,
		Q_CHK, Q_R1, Q_R2, Q_R3, Q_F1, Q_F2, DONE
	} state_t;

	state_t state_q;

	// Held request.
	logic signed [31:0] slope_q;
	logic signed [47:0] icpt_q;
	logic signed [31:0] x_q;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] lo_q, hi_q, mid_q;

	chull_pkg::status_t status_q;
	logic signed [63:0] best_q;

	// Pop test operands and previous line.
	chull_pkg::line_t   l1_q;
	logic signed [48:0] db31_q, db21_q;
	logic signed [32:0] da21_q, da31_q;
	logic signed [81:0] prod_p, prod_q;

	// Line evaluation pipeline.
	logic signed [63:0] e1_q, v1_q;
	logic signed [47:0] ei_q;
	logic signed [63:0] eval_sum;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr;
	chull_pkg::line_t  rd_data, wr_data;

	logic [CW+12:0] cnt_ext;
	logic [AW:0]    mid_sum;
	logic [AW-1:0]  mid_c;
	logic           accept;

	logic [63:0] out_best_q;
	logic [12:0] out_cnt_q;
	logic [1:0]  out_status_q;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == IDLE);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c    = mid_sum[AW:1];
	assign eval_sum = e1_q + {{16{ei_q[47]}}, ei_q};
	assign cnt_ext  = {13'b0, cnt_q};

	// The memory is read in the state before the one that uses the data. A write
	// happens only in PUSH, which always ends the transaction, so no read can
	// overlap it.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			IDLE: begin
				rd_en   = accept;
				rd_addr = AW'(cnt_q - CW'(1));
			end
			POP_CHK: begin
				rd_en   = 1'b1;
				rd_addr = AW'(cnt_q - CW'(2));
			end
			POP_R1: begin
				rd_en   = 1'b1;
				rd_addr = AW'(cnt_q - CW'(1));
			end
			Q_CHK: begin
				rd_en   = 1'b1;
				rd_addr = (lo_q < hi_q) ? mid_c : lo_q;
			end
			Q_R1: begin
				rd_en   = 1'b1;
				rd_addr = mid_q + AW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign wr_en         = (state_q == PUSH);
	assign wr_data.slope = slope_q;
	assign wr_data.icpt  = icpt_q;

	chull_mem #(
		.DEPTH (HULL_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Cross-multiplied pop test: the middle of the top two lines and the new
	// line is dropped when (b3-b1)*(a2-a1) >= (b2-b1)*(a3-a1).
	chull_mul u_mul_p (
		.clk (clk),
		.a   (db31_q),
		.b   (da21_q),
		.p   (prod_p)
	);

	chull_mul u_mul_q (
		.clk (clk),
		.a   (db21_q),
		.b   (da31_q),
		.p   (prod_q)
	);

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			slope_q <= $signed(s_tdata[31:0]);
			icpt_q  <= $signed(s_tdata[79:32]);
			x_q     <= $signed(s_tdata[111:80]);
		end
		if (state_q == POP_R1) begin
			l1_q <= rd_data;
		end
		if (state_q == POP_R2) begin
			db31_q <= {icpt_q[47], icpt_q} - {l1_q.icpt[47], l1_q.icpt};
			db21_q <= {rd_data.icpt[47], rd_data.icpt} - {l1_q.icpt[47], l1_q.icpt};
			da21_q <= {rd_data.slope[31], rd_data.slope} - {l1_q.slope[31], l1_q.slope};
			da31_q <= {slope_q[31], slope_q} - {l1_q.slope[31], l1_q.slope};
		end
		if (state_q == Q_R1 || state_q == Q_R2 || state_q == Q_F1) begin
			e1_q <= rd_data.slope * x_q;
			ei_q <= rd_data.icpt;
		end
		if (state_q == Q_R2) begin
			v1_q <= eval_sum;
		end
		if (state_q == Q_CHK) begin
			mid_q <= mid_c;
		end
	end

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cnt_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			status_q     <= chull_pkg::ST_OK;
			best_q       <= '0;
			m_tvalid     <= 1'b0;
			out_best_q   <= '0;
			out_cnt_q    <= '0;
			out_status_q <= '0;
		end else begin
			// In DONE the result register is refilled instead.
			if (m_tvalid && m_tready && state_q != DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						status_q <= chull_pkg::ST_OK;
						best_q   <= '0;
						lo_q     <= '0;
						hi_q     <= AW'(cnt_q - CW'(1));
						case (chull_pkg::req_t'(s_tuser))
							chull_pkg::REQ_INSERT: begin
								state_q <= (cnt_q == '0) ? PUSH : INS_TOP;
							end
							chull_pkg::REQ_QUERY: begin
								if (cnt_q == '0) begin
									status_q <= chull_pkg::ST_EMPTY;
									state_q  <= DONE;
								end else begin
									state_q <= Q_CHK;
								end
							end
							chull_pkg::REQ_CLEAR: begin
								cnt_q   <= '0;
								state_q <= DONE;
							end
							default: begin
								state_q <= DONE;
							end
						endcase
					end
				end
				INS_TOP: begin
					if (rd_data.slope > slope_q) begin
						status_q <= chull_pkg::ST_SLOPE;
						state_q  <= DONE;
					end else if (rd_data.slope == slope_q && rd_data.icpt >= icpt_q) begin
						state_q <= DONE;
					end else if (cnt_q == CW'(HULL_DEPTH)) begin
						status_q <= chull_pkg::ST_FULL;
						state_q  <= DONE;
					end else begin
						// An equal slope with a smaller intercept is replaced.
						if (rd_data.slope == slope_q) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= POP_CHK;
					end
				end
				POP_CHK: begin
					state_q <= (cnt_q >= CW'(2)) ? POP_R1 : PUSH;
				end
				POP_R1: state_q <= POP_R2;
				POP_R2: state_q <= POP_M1;
				POP_M1: state_q <= POP_M2;
				POP_M2: state_q <= POP_M3;
				POP_M3: begin
					if (prod_p >= prod_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= POP_CHK;
					end else begin
						state_q <= PUSH;
					end
				end
				PUSH: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= DONE;
				end
				Q_CHK: begin
					state_q <= (lo_q < hi_q) ? Q_R1 : Q_F1;
				end
				Q_R1: state_q <= Q_R2;
				Q_R2: state_q <= Q_R3;
				Q_R3: begin
					if (v1_q < eval_sum) begin
						lo_q <= mid_q + AW'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= Q_CHK;
				end
				Q_F1: state_q <= Q_F2;
				Q_F2: begin
					best_q  <= eval_sum;
					state_q <= DONE;
				end
				DONE: begin
					// The result register frees as soon as the last one is taken.
					if (!m_tvalid || m_tready) begin
						m_tvalid     <= 1'b1;
						out_best_q   <= best_q;
						out_cnt_q    <= cnt_ext[12:0];
						out_status_q <= status_q;
						state_q      <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_tdata = {3'b000, out_cnt_q, out_best_q};
	assign m_tuser = out_status_q;

	// The line count never exceeds the hull depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HULL_DEPTH))
		else $error("line count above hull depth");

	// A query on an empty hull reports a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == chull_pkg::ST_EMPTY) |-> (m_tdata[63:0] == 64'd0))
		else $error("empty query with nonzero value");

	// The line count only moves while a transaction is being worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IDLE && !accept) |=> $stable(cnt_q))
		else $error("line count changed while idle");

	// A memory write never targets an entry at or beyond the hull depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cnt_q < CW'(HULL_DEPTH)))
		else $error("push into full hull");

endmodule

`default_nettype wire

@@ hw/rtl/chull_mem.sv @@
// ----------------------------------------------------------------------------
// chull_mem: line store of the hull
// Synchronous memory with one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module chull_mem #(
	parameter int DEPTH = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire chull_pkg::line_t             wr_data,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	output chull_pkg::line_t                  rd_data
);

	chull_pkg::line_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/chull_mul.sv @@
// ----------------------------------------------------------------------------
// chull_mul: exact 49 x 33 bit signed multiplier
// Two partial products in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module chull_mul (
	input  wire logic               clk,
	input  wire logic signed [48:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [81:0]      p
);

	logic signed [58:0] plo_s1;
	logic signed [56:0] phi_s1;

	always_ff @(posedge clk) begin
		// The low 25 bits of a are taken as unsigned, the upper 24 as signed.
		plo_s1 <= $signed({1'b0, a[24:0]}) * b;
		phi_s1 <= $signed(a[48:25]) * b;
		p      <= $signed({phi_s1, 25'b0}) + $signed({{23{plo_s1[58]}}, plo_s1});
	end

endmodule

`default_nettype wire
